[rtl/lfsa_pkg.sv]
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared constants and codes of the lowest free slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

   // default sizes
   localparam int SLOT_COUNT_DEF  = 64;
   localparam int OWNER_COUNT_DEF = 1024;
   localparam int COUNT_WIDTH_DEF = 16;

   // port field widths
   localparam int OP_W       = 1;
   localparam int OWNER_ID_W = 10;
   localparam int SLOT_W     = 7;
   localparam int STATUS_W   = 2;
   localparam int USES_W     = 16;
   localparam int CSR_W      = 7;

   localparam logic [CSR_W-1:0] CSR_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_ARRIVE = 1'b0;
   localparam logic [OP_W-1:0] OP_DEPART = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOC   = 2'd0,
      STATUS_FREED   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NO_SLOT = 2'd3
   } status_type;

endpackage

[rtl/lfsa_ram.sv]
// ----------------------------------------------------------------------------
// lfsa_ram
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module lfsa_ram #(
   parameter int DEPTH = lfsa_pkg::OWNER_COUNT_DEF,
   parameter int WIDTH = lfsa_pkg::SLOT_W,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lfsa_free_finder.sv]
// ----------------------------------------------------------------------------
// lfsa_free_finder
// Finds the lowest clear bit of the busy map.
// ----------------------------------------------------------------------------
module lfsa_free_finder #(
   parameter int SLOT_COUNT = lfsa_pkg::SLOT_COUNT_DEF,
   localparam int IW        = $clog2(SLOT_COUNT)
) (
   input  logic [SLOT_COUNT-1:0] busy_map,
   output logic                  found,
   output logic [IW-1:0]         free_idx
);

   logic [SLOT_COUNT-1:0] lowest_zero;

   // isolate lowest zero bit: ~b & (b + 1)
   assign lowest_zero = ~busy_map & (busy_map + SLOT_COUNT'(1));
   assign found       = |lowest_zero;

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         free_idx = free_idx | (lowest_zero[i] ? IW'(i) : '0);
      end
   end

endmodule

[rtl/lowest_free_slot_allocator.sv]
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// Hands out the lowest free slot to arriving owners and frees it on depart.
// ----------------------------------------------------------------------------
// In the cycle start is taken, the owner table and the use-counter memory
// are read (registered read); in the next cycle the entries are updated and
// written back. The result shows on the rsp_ ports with strobe high in the
// cycle after that, and busy is already low then, so a new item can be
// started as soon as that result shows. The receiver cannot hold results
// off. After reset a clearing pass wipes both memories while busy stays
// high; the csr port takes writes at any time.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator #(
   parameter int SLOT_COUNT  = lfsa_pkg::SLOT_COUNT_DEF,
   parameter int OWNER_COUNT = lfsa_pkg::OWNER_COUNT_DEF,
   parameter int COUNT_WIDTH = lfsa_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // item in
   input  logic                               start,
   output logic                               busy,
   input  logic [lfsa_pkg::OP_W-1:0]          req_op,
   input  logic [lfsa_pkg::OWNER_ID_W-1:0]    req_owner_id,
   // result out
   output logic                               strobe,
   output logic [$clog2(SLOT_COUNT + 1)-1:0]  rsp_slot,
   output logic [lfsa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [COUNT_WIDTH-1:0]             rsp_slot_uses,
   output logic                               rsp_counted,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lfsa_pkg::CSR_W-1:0]         csr_data
);

   localparam int SLOT_W      = $clog2(SLOT_COUNT + 1);
   localparam int USES_W      = COUNT_WIDTH;
   localparam int OWNER_ID_W  = lfsa_pkg::OWNER_ID_W;
   localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
   localparam int SLOT_NUM_W  = $clog2(SLOT_COUNT + 1);
   localparam int OWNER_IDX_W = $clog2(OWNER_COUNT);
   localparam int ENTRY_W     = SLOT_NUM_W + 1;
   localparam int CLR_DEPTH   = (OWNER_COUNT > SLOT_COUNT) ? OWNER_COUNT : SLOT_COUNT;
   localparam int CLR_W       = $clog2(CLR_DEPTH);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // owner id wraps modulo OWNER_COUNT (restoring remainder, narrow steps)
   function automatic logic [OWNER_IDX_W-1:0] owner_wrap(input logic [OWNER_ID_W-1:0] id);
      logic [31:0] rem;
      logic [31:0] sub;
      rem = 32'(id);
      for (int k = OWNER_ID_W - 1; k >= 0; k--) begin
         sub = 32'(OWNER_COUNT) << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return OWNER_IDX_W'(rem);
   endfunction

   state_type                 state_ff;
   logic [CLR_W-1:0]          clr_ff;
   logic [lfsa_pkg::CSR_W-1:0] counted_ff;
   logic [SLOT_COUNT-1:0]     busy_map_ff;
   logic [SLOT_COUNT-1:0]     busy_map_in;
   logic                      op_ff;
   logic [OWNER_IDX_W-1:0]    owner_ff;
   logic [SLOT_IDX_W-1:0]     free_idx_ff;
   logic                      found_ff;

   logic                      strobe_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [lfsa_pkg::STATUS_W-1:0] status_ff;
   logic [USES_W-1:0]         uses_ff;
   logic                      counted_out_ff;

   logic                      accept;
   logic [OWNER_IDX_W-1:0]    owner_idx;
   logic                      find_found;
   logic [SLOT_IDX_W-1:0]     find_idx;

   logic                      own_we;
   logic [OWNER_IDX_W-1:0]    own_waddr;
   logic [ENTRY_W-1:0]        own_wdata;
   logic [ENTRY_W-1:0]        own_rdata;
   logic                      cnt_we;
   logic [SLOT_IDX_W-1:0]     cnt_waddr;
   logic [COUNT_WIDTH-1:0]    cnt_wdata;
   logic [COUNT_WIDTH-1:0]    cnt_rdata;

   logic                      own_valid;
   logic [SLOT_NUM_W-1:0]     held;
   logic [SLOT_IDX_W-1:0]     held_idx;
   logic [SLOT_NUM_W-1:0]     alloc_num;
   logic                      is_counted;
   logic [COUNT_WIDTH-1:0]    cnt_next;

   logic [SLOT_W-1:0]         slot_in;
   lfsa_pkg::status_type      status_in;
   logic [USES_W-1:0]         uses_in;
   logic                      counted_in;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign owner_idx = owner_wrap(req_owner_id);

   lfsa_free_finder #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_finder (
      .busy_map (busy_map_ff),
      .found    (find_found),
      .free_idx (find_idx)
   );

   lfsa_ram #(
      .DEPTH (OWNER_COUNT),
      .WIDTH (ENTRY_W)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_addr (owner_idx),
      .rd_data (own_rdata)
   );

   lfsa_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (COUNT_WIDTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (find_idx),
      .rd_data (cnt_rdata)
   );

   // entry fields read back for the item in flight
   assign own_valid  = own_rdata[ENTRY_W-1];
   assign held       = own_rdata[SLOT_NUM_W-1:0];
   assign held_idx   = SLOT_IDX_W'(held - SLOT_NUM_W'(1));
   assign alloc_num  = SLOT_NUM_W'(free_idx_ff) + SLOT_NUM_W'(1);
   assign is_counted = (32'(alloc_num) <= 32'(counted_ff));
   assign cnt_next   = (is_counted && (cnt_rdata != '1)) ? cnt_rdata + COUNT_WIDTH'(1)
                                                         : cnt_rdata;

   always_comb begin
      own_we      = 1'b0;
      own_waddr   = owner_ff;
      own_wdata   = '0;
      cnt_we      = 1'b0;
      cnt_waddr   = free_idx_ff;
      cnt_wdata   = cnt_next;
      busy_map_in = busy_map_ff;
      slot_in     = '0;
      status_in   = lfsa_pkg::STATUS_FULL;
      uses_in     = '0;
      counted_in  = 1'b0;
      if (state_ff == ST_CLEAR) begin
         own_we    = 1'b1;
         own_waddr = OWNER_IDX_W'(clr_ff);
         cnt_we    = 1'b1;
         cnt_waddr = SLOT_IDX_W'(clr_ff);
         cnt_wdata = '0;
      end else if (state_ff == ST_EXEC) begin
         if (op_ff == lfsa_pkg::OP_ARRIVE) begin
            if (found_ff) begin
               own_we                   = 1'b1;
               own_wdata                = {1'b1, alloc_num};
               cnt_we                   = 1'b1;
               busy_map_in[free_idx_ff] = 1'b1;
               slot_in                  = SLOT_W'(alloc_num);
               status_in                = lfsa_pkg::STATUS_ALLOC;
               uses_in                  = USES_W'(cnt_next);
               counted_in               = is_counted;
            end
         end else if (own_valid) begin
            own_we    = 1'b1;
            own_wdata = {1'b0, held};
            if (32'(held_idx) < 32'(SLOT_COUNT)) begin
               busy_map_in[held_idx] = 1'b0;
            end
            slot_in   = SLOT_W'(held);
            status_in = lfsa_pkg::STATUS_FREED;
         end else begin
            status_in = lfsa_pkg::STATUS_NO_SLOT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + CLR_W'(1);
               if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               strobe_ff      <= 1'b1;
               slot_ff        <= slot_in;
               status_ff      <= status_in;
               uses_ff        <= uses_in;
               counted_out_ff <= counted_in;
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // item fields captured at start
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         owner_ff    <= owner_idx;
         free_idx_ff <= find_idx;
         found_ff    <= find_found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_map_ff <= '0;
         counted_ff  <= lfsa_pkg::CSR_RESET;
      end else begin
         busy_map_ff <= busy_map_in;
         if (csr_valid && csr_ready) begin
            counted_ff <= csr_data;
         end
      end
   end

   assign strobe        = strobe_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_status    = status_ff;
   assign rsp_slot_uses = uses_ff;
   assign rsp_counted   = counted_out_ff;

   // the result strobe is never high on consecutive cycles
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      strobe |=> !strobe)
      else $error("result strobe on two cycles in a row");

   // every accepted item gives its result, with strobe raised after the write-back state
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 strobe)
      else $error("accepted item gave no result");

   // an allocation always names a real slot
   a_alloc_slot: assert property (@(posedge clock) disable iff (reset)
      (strobe && (rsp_status == lfsa_pkg::STATUS_ALLOC)) |-> (rsp_slot != '0))
      else $error("allocation without slot number");

   // the busy map only moves while an item is being written back
   a_map_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> $stable(busy_map_ff))
      else $error("busy map changed outside write-back");

endmodule
